/* rtl/srfp_pkg.sv */
// package for the servo reply frame parser
// holds the status codes, the frame constants and the result struct
// no dependencies
package srfp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned POS_W     = 3;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h3E;

    localparam logic [POS_W-1:0] POS_HUNT     = 3'd0;
    localparam logic [POS_W-1:0] POS_COMMAND  = 3'd1;
    localparam logic [POS_W-1:0] POS_ID       = 3'd2;
    localparam logic [POS_W-1:0] POS_HDR_DATA = 3'd3;
    localparam logic [POS_W-1:0] POS_HDR_SUM  = 3'd4;
    localparam logic [POS_W-1:0] POS_CNT_LOW  = 3'd5;
    localparam logic [POS_W-1:0] POS_CNT_HIGH = 3'd6;
    localparam logic [POS_W-1:0] POS_DATA_SUM = 3'd7;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HDR_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DATA_BAD = 2'd2;

    typedef struct packed {
        logic                done;
        logic [BYTE_W-1:0]   reply_command;
        logic [BYTE_W-1:0]   device_id;
        logic [COUNT_W-1:0]  encoder_count;
        logic [STATUS_W-1:0] frame_status;
    } result_t;

endpackage

/* rtl/servo_reply_frame_parser.sv */
// top level of the servo reply frame parser
// input register, parse core and result register
// depends on srfp_pkg and srfp_parse_core
//
// usage:
//   bytes enter on rx_byte with in_valid / in_ready; one result per reply frame
//   leaves on reply_command, device_id, encoder_count and frame_status with
//   out_valid / out_ready
//   a frame is the sync byte followed by seven bytes; the transaction of the last
//   byte yields the result, every other byte yields none
//   the last byte is held in the input register; its result is then registered
//   throughput: one byte per cycle, set by the combinational add and compare
//   in the parse core; the input register takes a byte every cycle while the
//   result register can move on
//   the user must write sync_byte through cfg_wr_en / cfg_wr_data while the
//   block is idle; the block does not enforce this; reset: sync byte returns
//   to 0x3E, the parser hunts, both registers empty; stall: a held result
//   stops the input register from advancing, so in_ready falls once it holds
//   a byte; at most one byte is taken in while out_ready stays low
module servo_reply_frame_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [srfp_pkg::BYTE_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [srfp_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srfp_pkg::BYTE_W-1:0]   reply_command,
    output logic [srfp_pkg::BYTE_W-1:0]   device_id,
    output logic [srfp_pkg::COUNT_W-1:0]  encoder_count,
    output logic [srfp_pkg::STATUS_W-1:0] frame_status
);

    logic [srfp_pkg::BYTE_W-1:0] sync_reg;
    logic                        in_valid_reg;
    logic [srfp_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg;
    srfp_pkg::result_t           out_reg;
    srfp_pkg::result_t           result;
    logic                        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    srfp_parse_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .sync_byte (sync_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg      <= srfp_pkg::SYNC_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sync_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance && result.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && result.done)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reply_command = out_reg.reply_command;
    assign device_id     = out_reg.device_id;
    assign encoder_count = out_reg.encoder_count;
    assign frame_status  = out_reg.frame_status;

endmodule

/* rtl/srfp_parse_core.sv */
// frame tracking state and checksum logic of the servo reply frame parser
// depends on srfp_pkg
module srfp_parse_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [srfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic [srfp_pkg::BYTE_W-1:0] sync_byte,
    output srfp_pkg::result_t           result
);

    logic [srfp_pkg::POS_W-1:0]  pos_reg;
    logic [srfp_pkg::POS_W-1:0]  pos_next;
    logic [srfp_pkg::BYTE_W-1:0] header_sum_reg;
    logic [srfp_pkg::BYTE_W-1:0] header_sum_next;
    logic                        header_ok_reg;
    logic                        header_ok_next;
    logic [srfp_pkg::BYTE_W-1:0] command_reg;
    logic [srfp_pkg::BYTE_W-1:0] command_next;
    logic [srfp_pkg::BYTE_W-1:0] id_reg;
    logic [srfp_pkg::BYTE_W-1:0] id_next;
    logic [srfp_pkg::BYTE_W-1:0] count_low_reg;
    logic [srfp_pkg::BYTE_W-1:0] count_low_next;
    logic [srfp_pkg::BYTE_W-1:0] count_high_reg;
    logic [srfp_pkg::BYTE_W-1:0] count_high_next;
    logic [srfp_pkg::BYTE_W-1:0] data_sum;

    assign data_sum = count_low_reg + count_high_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        header_sum_next = header_sum_reg;
        header_ok_next  = header_ok_reg;
        command_next    = command_reg;
        id_next         = id_reg;
        count_low_next  = count_low_reg;
        count_high_next = count_high_reg;
        result.done          = 1'b0;
        result.reply_command = command_reg;
        result.device_id     = id_reg;
        result.encoder_count = {count_high_reg, count_low_reg};
        result.frame_status  = srfp_pkg::STATUS_OK;
        if (!header_ok_reg)
        begin
            result.frame_status = srfp_pkg::STATUS_HDR_BAD;
        end
        else if (rx_byte != data_sum)
        begin
            result.frame_status = srfp_pkg::STATUS_DATA_BAD;
        end
        if (step)
        begin
            unique case (pos_reg)
                srfp_pkg::POS_HUNT:
                begin
                    if (rx_byte == sync_byte)
                    begin
                        header_sum_next = rx_byte;
                        pos_next        = srfp_pkg::POS_COMMAND;
                    end
                end
                srfp_pkg::POS_COMMAND:
                begin
                    command_next    = rx_byte;
                    header_sum_next = header_sum_reg + rx_byte;
                    pos_next        = srfp_pkg::POS_ID;
                end
                srfp_pkg::POS_ID:
                begin
                    id_next         = rx_byte;
                    header_sum_next = header_sum_reg + rx_byte;
                    pos_next        = srfp_pkg::POS_HDR_DATA;
                end
                srfp_pkg::POS_HDR_DATA:
                begin
                    header_sum_next = header_sum_reg + rx_byte;
                    pos_next        = srfp_pkg::POS_HDR_SUM;
                end
                srfp_pkg::POS_HDR_SUM:
                begin
                    header_ok_next = (rx_byte == header_sum_reg);
                    pos_next       = srfp_pkg::POS_CNT_LOW;
                end
                srfp_pkg::POS_CNT_LOW:
                begin
                    count_low_next = rx_byte;
                    pos_next       = srfp_pkg::POS_CNT_HIGH;
                end
                srfp_pkg::POS_CNT_HIGH:
                begin
                    count_high_next = rx_byte;
                    pos_next        = srfp_pkg::POS_DATA_SUM;
                end
                default:
                begin
                    // last frame byte: report and hunt again
                    result.done = 1'b1;
                    pos_next    = srfp_pkg::POS_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= srfp_pkg::POS_HUNT;
            header_sum_reg <= '0;
            header_ok_reg  <= 1'b0;
            command_reg    <= '0;
            id_reg         <= '0;
            count_low_reg  <= '0;
            count_high_reg <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            header_sum_reg <= header_sum_next;
            header_ok_reg  <= header_ok_next;
            command_reg    <= command_next;
            id_reg         <= id_next;
            count_low_reg  <= count_low_next;
            count_high_reg <= count_high_next;
        end
    end

endmodule
